[hw/rtl/swb_pkg.sv]
`default_nettype none
package swb_pkg;

  // Bus sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_PRE,
    PH_RST_LOW,
    PH_PRES,
    PH_SETTLE,
    PH_WR_LOW,
    PH_WR_REL,
    PH_RD_LOW,
    PH_RD_WAIT,
    PH_RD_TAIL
  } phase_e;

  // What the front end made of one tick.
  typedef enum logic [2:0] {
    CLS_TICK,
    CLS_RESET,
    CLS_WRITE,
    CLS_READ,
    CLS_IGNORE
  } cls_e;

  localparam logic [1:0] CMD_RESET = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] REG_RESET_LOW       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESENCE_WINDOW = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESENCE_SETTLE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WRITE_ONE_LOW   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WRITE_ZERO_LOW  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SLOT_RECOVERY   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_READ_SAMPLE     = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_READ_TAIL       = 3'd7;

  localparam logic [9:0] RST_RESET_LOW       = 10'd500;
  localparam logic [9:0] RST_PRESENCE_WINDOW = 10'd300;
  localparam logic [9:0] RST_PRESENCE_SETTLE = 10'd200;
  localparam logic [7:0] RST_WRITE_ONE_LOW   = 8'd7;
  localparam logic [7:0] RST_WRITE_ZERO_LOW  = 8'd65;
  localparam logic [7:0] RST_SLOT_RECOVERY   = 8'd5;
  localparam logic [7:0] RST_READ_SAMPLE     = 8'd12;
  localparam logic [7:0] RST_READ_TAIL       = 8'd65;

  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] presence_window;
    logic [9:0] presence_settle;
    logic [7:0] write_one_low;
    logic [7:0] write_zero_low;
    logic [7:0] slot_recovery;
    logic [7:0] read_sample_delay;
    logic [7:0] read_slot_tail;
  } cfg_t;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] write_data;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

endpackage
`default_nettype wire

[hw/rtl/single_wire_bus_master.sv]
// Single-wire bus master, one input transfer per microsecond tick.
// Input side is a queue: push with start_req_i, command_i, write_data_i and
// the sampled line_level_i; a transfer happens when push is high and full
// is low. Every tick gives exactly one result on the output queue: drive_low_o,
// busy_res_o, done_res_o, presence_o, read_data_o and rejected_o, shown while
// empty is low and taken when pop is high.
// Configuration is a write port (cfg_we_i, cfg_idx_i, cfg_data_i) taking one
// register per cycle; write it only while no tick is in flight.
// The input queue holds the tick until the sequencer takes it and writes its
// result into the output queue, from which the result is popped. The block
// takes one tick per cycle while the result queue has room; the sequencer
// updates its phase, timer and shift byte once per tick.
// Both queues hold two entries, so the front keeps accepting while a result
// waits; when pop stays low the result queue fills, the sequencer holds its
// state and full rises once the input queue fills as well.
// Reset empties both queues, puts the sequencer in idle with presence and
// read data at zero, and loads the default timing registers.
`default_nettype none
module single_wire_bus_master #(
  parameter int TimerBits      = 10,
  parameter int PrechargeTicks = 20
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         start_req_i,
  input  wire logic [1:0]                   command_i,
  input  wire logic [7:0]                   write_data_i,
  input  wire logic                         line_level_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              drive_low_o,
  output logic                              busy_res_o,
  output logic                              done_res_o,
  output logic                              presence_o,
  output logic      [7:0]                   read_data_o,
  output logic                              rejected_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [swb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [swb_pkg::CfgDataW-1:0] cfg_data_i
);
  import swb_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res;
  logic  item_valid, item_ready;

  swb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  swb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .start_req_i  (start_req_i),
    .command_i    (command_i),
    .write_data_i (write_data_i),
    .line_level_i (line_level_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  swb_back #(
    .TimerBits      (TimerBits),
    .PrechargeTicks (PrechargeTicks)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_o        (res),
    .empty_o      (empty),
    .pop_i        (pop)
  );

  assign drive_low_o = res.drive_low;
  assign busy_res_o  = res.busy_res;
  assign done_res_o  = res.done_res;
  assign presence_o  = res.presence;
  assign read_data_o = res.read_data;
  assign rejected_o  = res.rejected;

`ifndef ASSERT_OFF
  // A finished command leaves the bus idle after that tick.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && done_res_o) |-> !busy_res_o)
    else $error("done reported while still busy");

  // Every pull-low phase is followed by another phase of the same command.
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && drive_low_o) |-> busy_res_o)
    else $error("line driven low on a tick that ends the command");

  // With room for results, a waiting tick is taken by the sequencer.
  a_back_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && empty) |-> item_ready)
    else $error("sequencer stalled with an empty result queue");
`endif

endmodule
`default_nettype wire

[hw/rtl/swb_queue.sv]
`default_nettype none
module swb_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  input  wire logic [Width-1:0] wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_ready_i,
  output logic      [Width-1:0] rd_data_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_valid_i && !full_o;
  assign do_rd     = rd_ready_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_rd ? next_ptr(rd_ptr_q) : rd_ptr_q;
    case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/swb_front.sv]
`default_nettype none
module swb_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        start_req_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic        line_level_i,
  output logic             item_valid_o,
  input  wire logic        item_ready_i,
  output swb_pkg::item_t   item_o
);
  import swb_pkg::*;

  item_t item_in;
  logic  queue_empty;

  // Decode the request once here so the sequencer only sees a class.
  always_comb begin
    item_in.write_data = write_data_i;
    item_in.line_level = line_level_i;
    if (!start_req_i) begin
      item_in.cls = CLS_TICK;
    end else begin
      case (command_i)
        CMD_RESET: item_in.cls = CLS_RESET;
        CMD_WRITE: item_in.cls = CLS_WRITE;
        CMD_READ:  item_in.cls = CLS_READ;
        default:   item_in.cls = CLS_IGNORE;
      endcase
    end
  end

  swb_queue #(
    .Width($bits(item_t)),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_data_i  (item_in),
    .full_o     (full),
    .rd_ready_i (item_ready_i),
    .rd_data_o  (item_o),
    .empty_o    (queue_empty)
  );

  assign item_valid_o = !queue_empty;

endmodule
`default_nettype wire

[hw/rtl/swb_cfg.sv]
`default_nettype none
module swb_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [swb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [swb_pkg::CfgDataW-1:0] cfg_data_i,
  output swb_pkg::cfg_t                     cfg_o
);
  import swb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RESET_LOW:       cfg_d.reset_low_time    = cfg_data_i;
        REG_PRESENCE_WINDOW: cfg_d.presence_window   = cfg_data_i;
        REG_PRESENCE_SETTLE: cfg_d.presence_settle   = cfg_data_i;
        REG_WRITE_ONE_LOW:   cfg_d.write_one_low     = cfg_data_i[7:0];
        REG_WRITE_ZERO_LOW:  cfg_d.write_zero_low    = cfg_data_i[7:0];
        REG_SLOT_RECOVERY:   cfg_d.slot_recovery     = cfg_data_i[7:0];
        REG_READ_SAMPLE:     cfg_d.read_sample_delay = cfg_data_i[7:0];
        REG_READ_TAIL:       cfg_d.read_slot_tail    = cfg_data_i[7:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time    <= RST_RESET_LOW;
      cfg_q.presence_window   <= RST_PRESENCE_WINDOW;
      cfg_q.presence_settle   <= RST_PRESENCE_SETTLE;
      cfg_q.write_one_low     <= RST_WRITE_ONE_LOW;
      cfg_q.write_zero_low    <= RST_WRITE_ZERO_LOW;
      cfg_q.slot_recovery     <= RST_SLOT_RECOVERY;
      cfg_q.read_sample_delay <= RST_READ_SAMPLE;
      cfg_q.read_slot_tail    <= RST_READ_TAIL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[hw/rtl/swb_back.sv]
`default_nettype none
module swb_back #(
  parameter int TimerBits      = 10,
  parameter int PrechargeTicks = 20
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire swb_pkg::cfg_t  cfg_i,
  input  wire logic   item_valid_i,
  output logic        item_ready_o,
  input  wire swb_pkg::item_t item_i,
  output swb_pkg::res_t  res_o,
  output logic        empty_o,
  input  wire logic   pop_i
);
  import swb_pkg::*;

  // Phase lengths fit in 11 bits before saturation to the timer width.
  localparam int LenW = 11;
  localparam int CmpW = (TimerBits > LenW) ? TimerBits : LenW;
  localparam logic [CmpW-1:0] TMaxExt = CmpW'({TimerBits{1'b1}});
  localparam logic [LenW-1:0] PreLen  = LenW'(PrechargeTicks);

  phase_e               phase_q, phase_d, ph_s;
  logic [TimerBits-1:0] timer_q, timer_d, tm_s;
  logic [2:0]           bit_idx_q, bit_idx_d, bi_s;
  logic [7:0]           shift_q, shift_d, sh_s;
  logic [7:0]           last_rd_q, last_rd_d;
  logic                 pres_q, pres_d;
  logic                 fin, rejected, take, res_full;
  res_t                 res_in;

  function automatic logic [LenW-1:0] max1(input logic [LenW-1:0] v);
    return (v == '0) ? LenW'(1) : v;
  endfunction

  function automatic logic [TimerBits-1:0] sat(input logic [LenW-1:0] len);
    logic [CmpW-1:0] len_ext;
    len_ext = CmpW'(len);
    return (len_ext > TMaxExt) ? TimerBits'(TMaxExt) : TimerBits'(len_ext);
  endfunction

  assign take         = item_valid_i && !res_full;
  assign item_ready_o = !res_full;

  // A start on an idle bus opens its first phase on this same tick.
  always_comb begin : start_stage
    ph_s     = phase_q;
    tm_s     = timer_q;
    bi_s     = bit_idx_q;
    sh_s     = shift_q;
    rejected = (item_i.cls != CLS_TICK) && (phase_q != PH_IDLE);
    if (phase_q == PH_IDLE) begin
      case (item_i.cls)
        CLS_RESET: begin
          bi_s = '0;
          ph_s = PH_PRE;
          tm_s = sat(PreLen);
        end
        CLS_WRITE: begin
          bi_s = '0;
          sh_s = item_i.write_data;
          ph_s = PH_WR_LOW;
          tm_s = item_i.write_data[0] ? sat(max1(LenW'(cfg_i.write_one_low)))
                                      : sat(max1(LenW'(cfg_i.write_zero_low)));
        end
        CLS_READ: begin
          bi_s = '0;
          sh_s = '0;
          ph_s = PH_RD_LOW;
          tm_s = sat(LenW'(1));
        end
        default: ph_s = phase_q;
      endcase
    end
  end

  always_comb begin : next_state
    logic leave, tail_end;
    phase_d   = ph_s;
    timer_d   = tm_s;
    bit_idx_d = bi_s;
    shift_d   = sh_s;
    pres_d    = pres_q;
    last_rd_d = last_rd_q;
    fin       = 1'b0;
    leave     = 1'b0;
    tail_end  = 1'b0;

    if (ph_s != PH_IDLE) begin
      if (ph_s == PH_PRES && !item_i.line_level) begin
        pres_d = 1'b1;
        leave  = 1'b1;
      end else begin
        if (timer_d != '0) begin
          timer_d = timer_d - 1'b1;
        end
        if (timer_d == '0) begin
          if (ph_s == PH_RD_WAIT) begin
            shift_d[bi_s] = item_i.line_level;
          end
          if (ph_s == PH_PRES) begin
            pres_d = 1'b0;
          end
          leave = 1'b1;
        end
      end
    end

    if (leave) begin
      case (ph_s)
        PH_PRE: begin
          phase_d = PH_RST_LOW;
          timer_d = sat(max1(LenW'(cfg_i.reset_low_time)));
        end
        PH_RST_LOW: begin
          phase_d = PH_PRES;
          timer_d = sat(max1(LenW'(cfg_i.presence_window)));
        end
        PH_PRES: begin
          phase_d = PH_SETTLE;
          timer_d = sat(LenW'(cfg_i.presence_settle));
          // An empty settle time finishes the reset right away.
          if (timer_d == '0) begin
            phase_d = PH_IDLE;
            fin     = 1'b1;
          end
        end
        PH_SETTLE: begin
          phase_d = PH_IDLE;
          timer_d = '0;
          fin     = 1'b1;
        end
        PH_WR_LOW: begin
          phase_d = PH_WR_REL;
          timer_d = sat((shift_d[bi_s] ? max1(LenW'(cfg_i.write_zero_low))
                                       : max1(LenW'(cfg_i.write_one_low)))
                        + LenW'(cfg_i.slot_recovery));
        end
        PH_WR_REL: begin
          if (bi_s == 3'd7) begin
            phase_d   = PH_IDLE;
            timer_d   = '0;
            bit_idx_d = '0;
            fin       = 1'b1;
          end else begin
            bit_idx_d = bi_s + 1'b1;
            phase_d   = PH_WR_LOW;
            timer_d   = shift_d[bit_idx_d] ? sat(max1(LenW'(cfg_i.write_one_low)))
                                           : sat(max1(LenW'(cfg_i.write_zero_low)));
          end
        end
        PH_RD_LOW: begin
          phase_d = PH_RD_WAIT;
          timer_d = sat(max1(LenW'(cfg_i.read_sample_delay)));
        end
        PH_RD_WAIT: begin
          phase_d = PH_RD_TAIL;
          timer_d = sat(LenW'(cfg_i.read_slot_tail));
          // An empty tail goes straight on to the next slot or the end.
          tail_end = (timer_d == '0);
        end
        PH_RD_TAIL: tail_end = 1'b1;
        default: begin
          phase_d = PH_IDLE;
          timer_d = '0;
        end
      endcase
    end

    if (tail_end) begin
      if (bi_s == 3'd7) begin
        last_rd_d = shift_d;
        phase_d   = PH_IDLE;
        timer_d   = '0;
        bit_idx_d = '0;
        fin       = 1'b1;
      end else begin
        bit_idx_d = bi_s + 1'b1;
        phase_d   = PH_RD_LOW;
        timer_d   = sat(LenW'(1));
      end
    end
  end

  always_comb begin : outputs
    res_in.drive_low = (ph_s == PH_RST_LOW) || (ph_s == PH_WR_LOW) || (ph_s == PH_RD_LOW);
    res_in.busy_res  = (phase_d != PH_IDLE);
    res_in.done_res  = fin;
    res_in.presence  = pres_d;
    res_in.read_data = last_rd_d;
    res_in.rejected  = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      timer_q   <= '0;
      bit_idx_q <= '0;
      shift_q   <= '0;
      last_rd_q <= '0;
      pres_q    <= 1'b0;
    end else if (take) begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      last_rd_q <= last_rd_d;
      pres_q    <= pres_d;
    end
  end

  swb_queue #(
    .Width($bits(res_t)),
    .Depth(QueueDepth)
  ) u_res_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (take),
    .wr_data_i  (res_in),
    .full_o     (res_full),
    .rd_ready_i (pop_i),
    .rd_data_o  (res_o),
    .empty_o    (empty_o)
  );

endmodule
`default_nettype wire
